// ===== sv/bdq_pkg.sv =====
// Shared constants and types for the button dismiss qualifier.
package bdq_pkg;

	// Field widths
	localparam int unsigned BTN_W  = 32;
	localparam int unsigned TIME_W = 48;
	localparam int unsigned THR_W  = 24;
	localparam int unsigned CFG_W  = 32;

	// Stream payload widths (padded to whole bytes)
	localparam int unsigned IN_DATA_W  = 80;
	localparam int unsigned OUT_DATA_W = 8;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_CLOSE_MASK  = 2'd0,
		REG_CANCEL_MASK = 2'd1,
		REG_HOLD_THR    = 2'd2
	} cfg_reg_t;

	// Register reset values
	localparam logic [BTN_W-1:0] CLOSE_MASK_RST  = 32'h0000_4000;
	localparam logic [BTN_W-1:0] CANCEL_MASK_RST = 32'h0000_0000;
	localparam logic [THR_W-1:0] HOLD_THR_RST    = 24'd220000;

	// One result item
	typedef struct packed {
		logic dismissed_now;
		logic canceled;
		logic visible;
	} result_t;

endpackage

// ===== sv/button_dismiss_qualifier_core.sv =====
// Button dismiss qualifier: samples buttons and decides when a modal box closes.
//
// Usage:
//   s_axis carries one sample per item: tdata[31:0] buttons, tdata[79:32] time_us.
//   m_axis returns one result per sample: tdata[0] visible, tdata[1] canceled,
//   tdata[2] dismissed_now, tdata[7:3] zero.
//   cfg_we/cfg_index/cfg_data write close_mask (0), cancel_mask (1) and
//   hold_threshold_us (2); write only while no sample is in flight.
// Timing:
//   A sample sits in the input register, is qualified by a single pass of
//   compare and 48-bit subtract logic, and its result is written into the
//   output register when the input stage advances.
//   Throughput is one sample per cycle while m_axis_tready stays high, set by
//   the state update loop.
// Reset:
//   arst_n clears both stages and restores the registers and the box to open,
//   unprimed. The first sample after reset primes the block and disarms it.
// Back-pressure:
//   While m_axis_tready is low the result holds; one more sample is taken into
//   the input register, then s_axis_tready drops until the result is taken.
module button_dismiss_qualifier_core (
	input  logic        clk,
	input  logic        arst_n,
	// Sample input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [79:0] s_axis_tdata,  // buttons[31:0], time_us[79:32]
	// Result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // visible[0], canceled[1], dismissed_now[2], zero[7:3]
	// Configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned BW = bdq_pkg::BTN_W;
	localparam int unsigned TW = bdq_pkg::TIME_W;
	localparam int unsigned HW = bdq_pkg::THR_W;

	// Configuration registers
	logic [BW-1:0] close_mask_q;
	logic [BW-1:0] cancel_mask_q;
	logic [HW-1:0] hold_thr_q;

	// Qualifier state
	logic          open_q;
	logic          cancel_q;
	logic          primed_q;
	logic          armed_q;
	logic [BW-1:0] prev_btn_q;
	logic [BW-1:0] held_q;
	logic [TW-1:0] start_q;

	// Input stage
	logic          valid_s1;
	logic [BW-1:0] btn_s1;
	logic [TW-1:0] time_s1;

	// Output stage
	logic             out_valid_q;
	bdq_pkg::result_t result_q;

	// Next-state values
	logic          primed_d;
	logic          armed_d;
	logic          open_d;
	logic          cancel_d;
	logic [BW-1:0] prev_btn_d;
	logic [BW-1:0] held_d;
	logic [TW-1:0] start_d;
	logic          fired;

	// Scratch terms of the armed path
	logic [BW-1:0] rising;
	logic          by_cancel;
	logic          by_close;
	logic [BW-1:0] group;
	logic [TW-1:0] start_eff;
	logic [TW-1:0] elapsed;
	logic          advance;

	// Stage handshake: stage 1 moves on when the output register is free
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			btn_s1  <= s_axis_tdata[BW-1:0];
			time_s1 <= s_axis_tdata[BW+TW-1:BW];
		end
	end

	// Qualification of one sample
	always_comb begin
		primed_d   = primed_q;
		armed_d    = armed_q;
		open_d     = open_q;
		cancel_d   = cancel_q;
		prev_btn_d = prev_btn_q;
		held_d     = held_q;
		start_d    = start_q;
		fired      = 1'b0;
		rising     = btn_s1 & ~prev_btn_q;
		by_cancel  = 1'b0;
		by_close   = 1'b0;
		group      = '0;
		start_eff  = (start_q == '0) ? time_s1 : start_q;
		elapsed    = time_s1 - start_eff;

		if (open_q) begin
			// first sample primes and disarms
			if (!primed_q) begin
				primed_d   = 1'b1;
				prev_btn_d = btn_s1;
				start_d    = '0;
				held_d     = '0;
				armed_d    = 1'b0;
			end

			if (!armed_d) begin
				// re-arm once every close and cancel button is released
				if ((btn_s1 & (close_mask_q | cancel_mask_q)) == '0) begin
					armed_d = 1'b1;
					start_d = '0;
					held_d  = '0;
				end
				prev_btn_d = btn_s1;
			end else begin
				// press edges, cancel first
				by_cancel = (cancel_mask_q != '0) && ((rising & cancel_mask_q) != '0);
				by_close  = !by_cancel && ((rising & close_mask_q) != '0);

				// hold fallback
				if (!by_cancel && !by_close) begin
					if (cancel_mask_q != '0 && (btn_s1 & cancel_mask_q) != '0) begin
						group = cancel_mask_q;
					end else if ((btn_s1 & close_mask_q) != '0) begin
						group = close_mask_q;
					end

					if (group == '0) begin
						start_d = '0;
						held_d  = '0;
					end else if (group != held_q) begin
						held_d  = group;
						start_d = time_s1;
					end else begin
						start_d = start_eff;
						if (elapsed >= {{(TW-HW){1'b0}}, hold_thr_q}) begin
							if (held_q == cancel_mask_q) begin
								by_cancel = 1'b1;
							end else if (held_q == close_mask_q) begin
								by_close = 1'b1;
							end
						end
					end
				end

				prev_btn_d = btn_s1;

				if (by_cancel || by_close) begin
					cancel_d = by_cancel;
					open_d   = 1'b0;
					armed_d  = 1'b0;
					primed_d = 1'b0;
					fired    = 1'b1;
				end
			end
		end
	end

	// State and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_mask_q  <= bdq_pkg::CLOSE_MASK_RST;
			cancel_mask_q <= bdq_pkg::CANCEL_MASK_RST;
			hold_thr_q    <= bdq_pkg::HOLD_THR_RST;
			open_q        <= 1'b1;
			cancel_q      <= 1'b0;
			primed_q      <= 1'b0;
			armed_q       <= 1'b1;
			prev_btn_q    <= '0;
			held_q        <= '0;
			start_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdq_pkg::REG_CLOSE_MASK: close_mask_q <= cfg_data[BW-1:0];
				bdq_pkg::REG_CANCEL_MASK: begin
					cancel_mask_q <= cfg_data[BW-1:0];
					cancel_q      <= 1'b0;
				end
				bdq_pkg::REG_HOLD_THR: hold_thr_q <= cfg_data[HW-1:0];
				default: ;
			endcase
		end else if (advance) begin
			open_q     <= open_d;
			cancel_q   <= cancel_d;
			primed_q   <= primed_d;
			armed_q    <= armed_d;
			prev_btn_q <= prev_btn_d;
			held_q     <= held_d;
			start_q    <= start_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.visible       <= open_d;
			result_q.canceled      <= cancel_d;
			result_q.dismissed_now <= fired;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, result_q};

	// A dismissing result always shows the box closed
	a_dismiss_closed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.dismissed_now |-> !result_q.visible)
		else $error("dismissal result shows box visible");

	// Once closed the box stays closed until reset
	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |=> !open_q)
		else $error("box reopened without reset");

	// A closed box is neither armed nor primed
	a_closed_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> !armed_q && !primed_q)
		else $error("closed box still armed or primed");

	// A sample leaving stage 1 always lands in the output register
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result lost after stage advance");

endmodule

// ===== test/dismiss_checker.sv =====
// Predicts each dismissal verdict from the observed samples and register writes, and compares.
`timescale 1ns / 100ps
module dismiss_checker
	import bdq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // buttons[31:0], time_us[79:32]
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,  // visible[0], canceled[1], dismissed_now[2]
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	output int                    outstanding,
	output int                    mismatches
);

	// Register copies
	logic [BTN_W-1:0]  close_m;
	logic [BTN_W-1:0]  cancel_m;
	logic [THR_W-1:0]  hold_thr;

	// Box state
	bit                box_open;
	bit                by_cancel_flag;
	bit                primed;
	bit                armed;
	logic [BTN_W-1:0]  prev_btn;
	logic [BTN_W-1:0]  held_group;
	logic [TIME_W-1:0] hold_start;

	result_t expected_verdicts[$];

	// Next verdict for one sample; advances the box state
	function automatic result_t qualify_sample(input logic [BTN_W-1:0] btn,
			input logic [TIME_W-1:0] now);
		result_t           r;
		bit                fired;
		bit                by_cancel;
		bit                by_close;
		logic [BTN_W-1:0]  rising;
		logic [BTN_W-1:0]  group;
		logic [TIME_W-1:0] elapsed;
		fired = 1'b0;
		by_cancel = 1'b0;
		by_close = 1'b0;
		if (box_open) begin
			// first sample after reset primes and disarms
			if (!primed) begin
				primed = 1'b1;
				prev_btn = btn;
				hold_start = '0;
				held_group = '0;
				armed = 1'b0;
			end
			if (!armed) begin
				// re-arm once every close and cancel button is up
				if ((btn & (close_m | cancel_m)) == '0) begin
					armed = 1'b1;
					hold_start = '0;
					held_group = '0;
				end
				prev_btn = btn;
			end else begin
				rising = btn & ~prev_btn;
				by_cancel = (cancel_m != '0) && ((rising & cancel_m) != '0);
				by_close = !by_cancel && ((rising & close_m) != '0);
				// no press edge: fall back to the hold timer
				if (!by_cancel && !by_close) begin
					group = '0;
					if (cancel_m != '0 && (btn & cancel_m) != '0)
						group = cancel_m;
					else if ((btn & close_m) != '0)
						group = close_m;
					if (group == '0) begin
						hold_start = '0;
						held_group = '0;
					end else if (group != held_group) begin
						held_group = group;
						hold_start = now;
					end else begin
						// zero start means not yet started
						if (hold_start == '0)
							hold_start = now;
						elapsed = now - hold_start;
						if (elapsed >= {{(TIME_W-THR_W){1'b0}}, hold_thr}) begin
							if (held_group == cancel_m)
								by_cancel = 1'b1;
							else if (held_group == close_m)
								by_close = 1'b1;
						end
					end
				end
				prev_btn = btn;
				if (by_cancel || by_close) begin
					by_cancel_flag = by_cancel;
					box_open = 1'b0;
					armed = 1'b0;
					primed = 1'b0;
					fired = 1'b1;
				end
			end
		end
		r.visible = box_open;
		r.canceled = by_cancel_flag;
		r.dismissed_now = fired;
		return r;
	endfunction

	// Watch writes, samples and results
	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			close_m = CLOSE_MASK_RST;
			cancel_m = CANCEL_MASK_RST;
			hold_thr = HOLD_THR_RST;
			box_open = 1'b1;
			by_cancel_flag = 1'b0;
			primed = 1'b0;
			armed = 1'b1;
			prev_btn = '0;
			held_group = '0;
			hold_start = '0;
			expected_verdicts.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_CLOSE_MASK: close_m = cfg_data[BTN_W-1:0];
					REG_CANCEL_MASK: begin
						cancel_m = cfg_data[BTN_W-1:0];
						by_cancel_flag = 1'b0;
					end
					REG_HOLD_THR: hold_thr = cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_verdicts.push_back(qualify_sample(s_axis_tdata[BTN_W-1:0],
					s_axis_tdata[BTN_W +: TIME_W]));
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[2:0]);
				if (expected_verdicts.size() == 0) begin
					$error("result item with no sample outstanding: tdata %h", m_axis_tdata);
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					if (got.visible !== want.visible) begin
						$error("visible: expected %0b, got %0b", want.visible, got.visible);
						mismatches++;
					end
					if (got.canceled !== want.canceled) begin
						$error("canceled: expected %0b, got %0b", want.canceled, got.canceled);
						mismatches++;
					end
					if (got.dismissed_now !== want.dismissed_now) begin
						$error("dismissed_now: expected %0b, got %0b",
							want.dismissed_now, got.dismissed_now);
						mismatches++;
					end
				end
			end
		end
		outstanding = expected_verdicts.size();
	end

endmodule

// ===== test/tb.sv =====
// Top of the dismiss qualifier testbench: clock, reset, sample and register stimulus, verdict.
`timescale 1ns / 100ps
module tb;
	import bdq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 43;
	localparam int PHASE_ITEMS = 40;
	localparam logic [TIME_W-1:0] TIME_TOP = '1;

	// How the last phase is meant to close the box
	typedef enum int {
		END_CANCEL_EDGE,
		END_CLOSE_EDGE,
		END_CANCEL_HOLD,
		END_CLOSE_HOLD
	} ending_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // buttons[31:0], time_us[79:32]
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // visible[0], canceled[1], dismissed_now[2]
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	int                    outstanding;
	int                    mismatches;
	int                    cycles;
	bit                    steady;
	logic [BTN_W-1:0]      cur_close;
	logic [BTN_W-1:0]      cur_cancel;
	logic [THR_W-1:0]      cur_thr;
	logic [BTN_W-1:0]      last_btn;
	logic [TIME_W-1:0]     clock_us;

	button_dismiss_qualifier_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	dismiss_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.outstanding   (outstanding),
		.mismatches    (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Random mask: empty, one button, every button or any pattern
	function automatic logic [BTN_W-1:0] pick_mask();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 32'h1 << $urandom_range(0, 31);
			2: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Offer one sample item, with a random gap unless in a steady stretch
	task automatic send_sample(input logic [BTN_W-1:0] btn, input logic [TIME_W-1:0] t);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {t, btn};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop offering and wait until every verdict is back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Rewrite all three registers while the block is idle
	task automatic write_regs(input logic [BTN_W-1:0] close_v, input logic [BTN_W-1:0] cancel_v,
			input logic [THR_W-1:0] thr_v);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_CLOSE_MASK;
		cfg_data <= close_v;
		@(posedge clk);
		cfg_index <= REG_CANCEL_MASK;
		cfg_data <= cancel_v;
		@(posedge clk);
		cfg_index <= REG_HOLD_THR;
		cfg_data <= {{(CFG_W-THR_W){1'b0}}, thr_v};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_close = close_v;
		cur_cancel = cancel_v;
		cur_thr = thr_v;
	endtask

	// Random samples; without presses, close and cancel buttons may only stay down or come up
	task automatic play(input int n, input bit presses, input int step_max);
		logic [BTN_W-1:0] raw;
		logic [BTN_W-1:0] drop;
		logic [BTN_W-1:0] mk;
		logic [BTN_W-1:0] btn;
		for (int i = 0; i < n; i++) begin
			mk = cur_close | cur_cancel;
			raw = $urandom;
			drop = $urandom & $urandom & $urandom;
			btn = presses ? raw : ((raw & ~mk) | (last_btn & mk & ~drop));
			clock_us = clock_us + $urandom_range(0, step_max);
			send_sample(btn, clock_us);
			last_btn = btn;
		end
	endtask

	// Result side: random stalls per item
	initial begin : result_sink
		int stall;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		ending_t          ending;
		logic [BTN_W-1:0] cm;
		logic [BTN_W-1:0] km;
		logic [THR_W-1:0] th;
		logic [63:0]      r64;
		bit               presses;
		int               step;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_CLOSE_MASK;
		cfg_data <= '0;
		steady = 1'b0;
		cur_close = CLOSE_MASK_RST;
		cur_cancel = CANCEL_MASK_RST;
		cur_thr = HOLD_THR_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// prime with close held, stay disarmed, then arm on release
		send_sample(32'h0000_4000, 48'd5);
		send_sample('1, TIME_TOP);
		send_sample(32'hFFFF_BFFF, '0);
		send_sample('0, 48'd1);

		// both masks empty: nothing can dismiss
		write_regs('0, '0, cur_thr);
		send_sample('1, TIME_TOP);
		send_sample('0, '0);
		send_sample(32'h3, 48'd10);

		// equal masks over held buttons; a timer started at time zero restarts
		write_regs(32'h1, 32'h1, 24'd1000);
		send_sample(32'h3, '0);
		send_sample(32'h3, 48'd50);
		send_sample(32'h3, 48'd1049);

		// cancel cleared: held group moves to close, elapsed time wraps past the top
		write_regs(32'h2, '0, 24'd1000);
		send_sample(32'h3, TIME_TOP - 48'd255);
		send_sample(32'h3, 48'd743);
		send_sample(32'h1, 48'd800);
		last_btn = 32'h1;

		// open-box phases: no press edges, holds kept shorter than the threshold
		for (int p = 0; p < PHASES; p++) begin
			cm = pick_mask();
			km = ($urandom_range(0, 5) == 0) ? cm : pick_mask();
			th = ($urandom_range(0, 3) == 0) ? '1 : THR_W'($urandom_range(64, 24'hFF_FFFF));
			write_regs(cm, km, th);
			steady = ($urandom_range(0, 3) == 0);
			r64 = {$urandom, $urandom};
			clock_us = $urandom_range(0, 1) ? r64[TIME_W-1:0] : TIME_TOP - $urandom_range(0, th);
			play(PHASE_ITEMS, 1'b0, th / 64);
			// release every close and cancel button so the next setting starts with no timer
			last_btn = $urandom & ~(cur_close | cur_cancel);
			clock_us = clock_us + 1;
			send_sample(last_btn, clock_us);
		end

		// closing phase: one dismissal of a randomly chosen kind, then the box stays shut
		ending = ending_t'($urandom_range(0, 3));
		presses = 1'b0;
		step = 64;
		th = THR_W'($urandom_range(0, 200));
		case (ending)
			END_CANCEL_EDGE: begin
				km = $urandom | (32'h1 << $urandom_range(0, 31));
				cm = pick_mask();
				th = '1;
				presses = 1'b1;
				step = 1000;
			end
			END_CLOSE_EDGE: begin
				km = '0;
				cm = $urandom | (32'h1 << $urandom_range(0, 31));
				th = '1;
				presses = 1'b1;
				step = 1000;
			end
			END_CANCEL_HOLD: begin
				km = last_btn & $urandom;
				if (km == '0)
					km = last_btn;
				cm = pick_mask();
			end
			default: begin
				km = '0;
				cm = last_btn & $urandom;
				if (cm == '0)
					cm = last_btn;
			end
		endcase
		write_regs(cm, km, th);
		steady = 1'b0;
		play(60, presses, step);

		// a cancel mask write after dismissal drops the canceled flag
		write_regs(cur_close, $urandom | 32'h1, cur_thr);
		play(5, 1'b1, 1000);
		settle();

		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
